[sv/ulcp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ulcp_pkg;

    // longest stored line, the byte after it ends the line
    localparam int MAX_LINE    = 30;
    localparam int POS_W       = $clog2(MAX_LINE + 1);
    localparam int COLOR_START = 9;
    localparam int VERB_N      = 3;
    localparam int COLOR_N     = 4;

    typedef logic [POS_W-1:0] pos_t;

    localparam logic [7:0] LINE_END = 8'd13;

    // reply kinds
    localparam logic [1:0] KIND_ID    = 2'd0;
    localparam logic [1:0] KIND_STATE = 2'd1;
    localparam logic [1:0] KIND_SET   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // command prefixes: id query, period set, state query
    localparam logic [7:0] VERB_TEXT [0:VERB_N-1][0:8] = '{
        '{"g", "e", "t", "_", "i", "d", 8'd0, 8'd0, 8'd0},
        '{"s", "e", "t", "_", "t", "i", "m", "e", 8'd0},
        '{"g", "e", "t", "_", "s", "t", "a", "t", "e"}
    };
    localparam int VERB_LEN [0:VERB_N-1] = '{6, 8, 9};

    // colour prefixes: green, red, yellow, blue
    localparam logic [7:0] COLOR_TEXT [0:COLOR_N-1][0:5] = '{
        '{"g", "r", "e", "e", "n", 8'd0},
        '{"r", "e", "d", 8'd0, 8'd0, 8'd0},
        '{"y", "e", "l", "l", "o", "w"},
        '{"b", "l", "u", "e", 8'd0, 8'd0}
    };
    localparam int COLOR_LEN [0:COLOR_N-1] = '{5, 3, 6, 4};

    // digit run phases
    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_RUN   = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;
    localparam logic [1:0] PH_NODIG = 2'd3;

endpackage

`default_nettype wire

[sv/uart_led_command_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// Command line parser for LED blink control. Each s_ transaction carries one
// received byte. Bytes build up a line of at most MAX_LINE (30) stored bytes;
// the line ends at a carriage return, or at the byte that arrives once the
// line is full, and that ending byte is dropped. Matching is incremental, so
// nothing is buffered: each byte updates the prefix candidates, the colour
// candidates and the decimal accumulator when taken. At every line end one
// m_ transaction gives the reply kind (id request, state request, period set
// or error), the LED selected and the period, saturated at 2^32-1; the led
// and period fields are zero unless the kind is period set. Bytes inside a
// line give no output. The block takes one byte per clock; the only wait is
// when a reply is still held in the output register and m_tready is low,
// because the reply register has one entry. The reply is registered and is
// valid in the cycle after its line-ending byte is accepted.
module uart_led_command_parser
    import ulcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [1:0] reply_kind, [3:2] led_select,
                                        // [35:4] period_ms, [39:36] zero
);

    // line state
    pos_t                       line_pos_reg, line_pos_next;
    logic [VERB_N-1:0]          verb_reg, verb_next;
    logic [COLOR_N-1:0]         color_reg, color_next;
    pos_t                       color_end_reg, color_end_next;
    logic [31:0]                digit_val_reg, digit_val_next;
    logic [1:0]                 phase_reg, phase_next;

    // reply register
    logic                       m_valid_reg;
    logic [35:0]                m_data_reg;

    logic                       s_fire;
    logic                       line_end;
    logic                       is_digit;
    logic [3:0]                 digit;
    logic [35:0]                times_ten;
    logic [1:0]                 kind;
    logic [1:0]                 led;
    logic [31:0]                period;
    int                         off;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_data_reg};

    // the byte after a full line ends it, even if it is a carriage return
    assign line_end = (s_tdata == LINE_END) || (line_pos_reg == pos_t'(MAX_LINE));
    assign is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
    assign digit    = s_tdata[3:0];
    assign times_ten = ({4'd0, digit_val_reg} << 3) + ({4'd0, digit_val_reg} << 1)
                     + {32'd0, digit};

    // per-byte state update
    always_comb begin
        verb_next      = verb_reg;
        color_next     = color_reg;
        color_end_next = color_end_reg;
        digit_val_next = digit_val_reg;
        phase_next     = phase_reg;
        off            = int'(line_pos_reg) - COLOR_START;

        for (int i = 0; i < VERB_N; i++) begin
            if (int'(line_pos_reg) < VERB_LEN[i]) begin
                if (s_tdata != VERB_TEXT[i][line_pos_reg[3:0]]) begin
                    verb_next[i] = 1'b0;
                end
            end
        end

        for (int i = 0; i < COLOR_N; i++) begin
            if (off >= 0 && off < COLOR_LEN[i]) begin
                if (s_tdata != COLOR_TEXT[i][off[2:0]]) begin
                    color_next[i] = 1'b0;
                end
            end
        end

        // the first colour byte settles the colour, and so where the digits start
        if (line_pos_reg == pos_t'(COLOR_START)) begin
            for (int i = 0; i < COLOR_N; i++) begin
                if (color_next[i]) begin
                    color_end_next = pos_t'(COLOR_START + COLOR_LEN[i] + 1);
                end
            end
        end

        if (color_end_reg != '0 && line_pos_reg >= color_end_reg) begin
            case (phase_reg)
                PH_WAIT: begin
                    if (is_digit) begin
                        digit_val_next = {28'd0, digit};
                        phase_next     = PH_RUN;
                    end else begin
                        phase_next     = PH_NODIG;
                    end
                end
                PH_RUN: begin
                    if (is_digit) begin
                        // saturate at all ones
                        digit_val_next = (times_ten[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                    : times_ten[31:0];
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        line_pos_next = line_pos_reg + pos_t'(1);
    end

    // reply for the line held in the state registers
    always_comb begin
        kind   = KIND_ERROR;
        led    = 2'd0;
        period = 32'd0;
        if (verb_reg[0] && int'(line_pos_reg) >= VERB_LEN[0]) begin
            kind = KIND_ID;
        end else if (verb_reg[1] && int'(line_pos_reg) >= VERB_LEN[1]) begin
            for (int i = 0; i < COLOR_N; i++) begin
                if (color_reg[i] && int'(line_pos_reg) >= COLOR_START + COLOR_LEN[i]
                    && (phase_reg == PH_RUN || phase_reg == PH_DONE)
                    && digit_val_reg != 32'd0) begin
                    kind   = KIND_SET;
                    led    = 2'(i);
                    period = digit_val_reg;
                end
            end
        end else if (verb_reg[2] && int'(line_pos_reg) >= VERB_LEN[2]) begin
            kind = KIND_STATE;
        end
    end

    // line state registers: every line starts empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_pos_reg  <= '0;
            verb_reg      <= '1;
            color_reg     <= '1;
            color_end_reg <= '0;
            digit_val_reg <= '0;
            phase_reg     <= PH_WAIT;
        end else if (s_fire) begin
            if (line_end) begin
                line_pos_reg  <= '0;
                verb_reg      <= '1;
                color_reg     <= '1;
                color_end_reg <= '0;
                digit_val_reg <= '0;
                phase_reg     <= PH_WAIT;
            end else begin
                line_pos_reg  <= line_pos_next;
                verb_reg      <= verb_next;
                color_reg     <= color_next;
                color_end_reg <= color_end_next;
                digit_val_reg <= digit_val_next;
                phase_reg     <= phase_next;
            end
        end
    end

    // reply register, refilled in the same cycle it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && line_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && line_end) begin
            m_data_reg <= {period, led, kind};
        end
    end

endmodule

`default_nettype wire

[tb/tb_uart_led_command_parser.sv]
`timescale 1ns / 1ps

module tb_uart_led_command_parser
    import ulcp_pkg::*;
();

    // generous cycle ceiling, far above the slowest legal run
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_BYTES  = 150;
    localparam int RANDOM_LINES  = 8;
    localparam int DRAIN_CYCLES  = 20;

    // command prefix rows in the prefix table
    localparam int VERB_ID    = 0;
    localparam int VERB_SET   = 1;
    localparam int VERB_STATE = 2;

    // one reply as the parser should report it
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  led;
        logic [31:0] period;
    } reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;             // [1:0] reply_kind, [3:2] led_select,
                                      // [35:4] period_ms, [39:36] zero

    uart_led_command_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // bytes waiting to be sent, and replies the parser still owes us
    logic [7:0] rx_bytes_todo [$];
    reply_t     pending_replies [$];
    int         errors = 0;

    // shadow copy of the line parser state
    int         line_pos;
    logic [2:0] verb_live;
    logic [3:0] color_live;
    int         color_end;
    logic [31:0] digit_val;
    logic [1:0] digit_phase;

    int send_gap   = 0;
    int send_calm  = 0;
    int recv_stall = 0;
    int recv_calm  = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // every line starts from an empty buffer
    function automatic void restart_line();
        line_pos    = 0;
        verb_live   = '1;
        color_live  = '1;
        color_end   = 0;
        digit_val   = '0;
        digit_phase = PH_WAIT;
    endfunction

    // predict the effect of one accepted byte, queue a reply at line end
    task automatic parse_byte(input logic [7:0] b);
        reply_t      r;
        int          p;
        logic [63:0] acc;
        logic        is_dig;
        is_dig = (b >= "0") && (b <= "9");
        if (b != LINE_END && line_pos < MAX_LINE) begin
            p = line_pos;
            // drop command prefixes that no longer match
            for (int i = 0; i < VERB_N; i++) begin
                if (p < VERB_LEN[i] && b != VERB_TEXT[i][p])
                    verb_live[i] = 1'b0;
            end
            // colour words start at a fixed column
            for (int i = 0; i < COLOR_N; i++) begin
                if (p >= COLOR_START && p < COLOR_START + COLOR_LEN[i] &&
                    b != COLOR_TEXT[i][p - COLOR_START])
                    color_live[i] = 1'b0;
            end
            // the digit column is fixed once the first colour byte is seen,
            // the last surviving candidate decides it
            if (p == COLOR_START) begin
                for (int i = 0; i < COLOR_N; i++) begin
                    if (color_live[i])
                        color_end = COLOR_START + COLOR_LEN[i] + 1;
                end
            end
            // decimal accumulate with saturation
            if (color_end != 0 && p >= color_end) begin
                if (digit_phase == PH_WAIT) begin
                    if (is_dig) begin
                        digit_val   = 32'(b - "0");
                        digit_phase = PH_RUN;
                    end else begin
                        digit_phase = PH_NODIG;
                    end
                end else if (digit_phase == PH_RUN) begin
                    if (is_dig) begin
                        acc = 64'(digit_val) * 64'd10 + 64'(b - "0");
                        digit_val = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                    end else begin
                        digit_phase = PH_DONE;
                    end
                end
            end
            line_pos++;
        end else begin
            // line end: decide the reply, prefixes tried in fixed order
            r.kind   = KIND_ERROR;
            r.led    = 2'd0;
            r.period = 32'd0;
            if (verb_live[VERB_ID] && line_pos >= VERB_LEN[VERB_ID]) begin
                r.kind = KIND_ID;
            end else if (verb_live[VERB_SET] && line_pos >= VERB_LEN[VERB_SET]) begin
                for (int i = 0; i < COLOR_N; i++) begin
                    if (color_live[i] && line_pos >= COLOR_START + COLOR_LEN[i] &&
                        (digit_phase == PH_RUN || digit_phase == PH_DONE) &&
                        digit_val != 32'd0) begin
                        r.kind   = KIND_SET;
                        r.led    = 2'(i);
                        r.period = digit_val;
                    end
                end
            end else if (verb_live[VERB_STATE] && line_pos >= VERB_LEN[VERB_STATE]) begin
                r.kind = KIND_STATE;
            end
            pending_replies.push_back(r);
            restart_line();
        end
    endtask

    // idle lengths: mostly short, a few long, with idle-free stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // filler byte of any value, never zero and never a carriage return
    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == LINE_END);
        return b;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        rx_bytes_todo.push_back(b);
    endtask

    // first count chars of a word, one position optionally corrupted
    task automatic push_word(input string s, input int flip, input int count);
        for (int i = 0; i < count; i++) begin
            if (i == flip)
                push_byte(rand_text_byte());
            else
                push_byte(s[i]);
        end
    endtask

    // first count chars of a command prefix, one position optionally corrupted
    task automatic push_verb(input int v, input int flip, input int count);
        for (int i = 0; i < count; i++) begin
            if (i == flip)
                push_byte(rand_text_byte());
            else
                push_byte(VERB_TEXT[v][i]);
        end
    endtask

    task automatic push_text(input string s);
        push_word(s, -1, s.len());
    endtask

    task automatic push_line(input string s);
        push_text(s);
        push_byte(LINE_END);
    endtask

    // whole period set prefix followed by the rest of the line
    task automatic push_set_line(input string rest);
        push_verb(VERB_SET, -1, VERB_LEN[VERB_SET]);
        push_line(rest);
    endtask

    // one random line, mostly well formed commands with random content
    task automatic push_random_line();
        string colors [4] = '{"green", "red", "yellow", "blue"};
        string w;
        int    pick;
        int    n;
        int    d;
        int    flip;
        int    v;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // period set command <sep> colour <sep> digits
            flip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : -1;
            push_verb(VERB_SET, flip, VERB_LEN[VERB_SET]);
            push_byte(rand_text_byte());
            w    = colors[$urandom_range(0, 3)];
            flip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w.len() - 1) : -1;
            push_word(w, flip, w.len());
            push_byte(rand_text_byte());
            n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 11);
            for (int k = 0; k < n; k++) begin
                d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                push_byte(8'h30 + 8'(d));
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 8)) push_byte(rand_text_byte());
            push_byte(LINE_END);
        end else if (pick < 75) begin
            // id or state query, maybe with trailing text
            v    = (pick < 60) ? VERB_ID : VERB_STATE;
            flip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, VERB_LEN[v] - 1) : -1;
            push_verb(v, flip, VERB_LEN[v]);
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 10)) push_byte(rand_text_byte());
            push_byte(LINE_END);
        end else if (pick < 85) begin
            // raw noise, any byte value, stray carriage returns included
            repeat ($urandom_range(0, 35)) push_byte(8'($urandom_range(0, 255)));
            push_byte(LINE_END);
        end else if (pick < 90) begin
            // full buffer, the next byte of any value ends the line
            repeat (MAX_LINE) push_byte(rand_text_byte());
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            // command prefix, possibly truncated
            v = $urandom_range(0, 2);
            push_verb(v, -1, $urandom_range(0, VERB_LEN[v]));
            push_byte(LINE_END);
        end
    endtask

    // driver: one byte per transaction, random idle between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (rx_bytes_todo.size() > 0) begin
                    s_tdata  <= rx_bytes_todo.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each reply transaction against the oldest prediction
    always @(posedge aclk) begin
        reply_t exp;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected reply, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    exp = pending_replies.pop_front();
                    if (m_tdata[1:0] !== exp.kind) begin
                        $display("%0t: reply_kind expected %0d actual %0d",
                                 $time, exp.kind, m_tdata[1:0]);
                        errors++;
                    end
                    if (m_tdata[3:2] !== exp.led) begin
                        $display("%0t: led_select expected %0d actual %0d",
                                 $time, exp.led, m_tdata[3:2]);
                        errors++;
                    end
                    if (m_tdata[35:4] !== exp.period) begin
                        $display("%0t: period_ms expected %0d actual %0d",
                                 $time, exp.period, m_tdata[35:4]);
                        errors++;
                    end
                    if (m_tdata[39:36] !== 4'd0) begin
                        $display("%0t: pad bits expected 0 actual %h",
                                 $time, m_tdata[39:36]);
                        errors++;
                    end
                end
            end
            // back-pressure: stall after some transactions, or now and then
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0)
                    recv_stall <= pick_gap(recv_calm);
            end
        end
    end

    initial begin
        int base;
        int lines;
        bit timed_out;
        timed_out = 1'b0;
        restart_line();

        // directed lines: each command, the error paths, saturation
        push_line("get_id");
        push_verb(VERB_STATE, -1, VERB_LEN[VERB_STATE]);
        push_byte(LINE_END);
        push_set_line(" green 5");
        push_set_line(":red=4294967296");             // saturates
        push_set_line(" yellow 4294967295");          // exact maximum
        push_set_line(" yellow x7");                  // no digit after separator
        push_set_line(" blue 000");                   // zero period
        push_set_line(" blue");                       // digit column past line end
        push_set_line(" purple 3");                   // unknown colour
        push_line("");                               // empty line
        push_line("hello");                          // unknown command
        push_line("get_i");                          // too short
        push_verb(VERB_SET, -1, VERB_LEN[VERB_SET]); // zero byte ends the run
        push_text(" red 1");
        push_byte(8'h00);
        push_line("9");
        // full buffer of 0xff, the carriage return after it is dropped
        repeat (MAX_LINE) push_byte(8'hFF);
        push_byte(LINE_END);
        // get_id padded to a full buffer, closing byte is swallowed
        push_text("get_id");
        repeat (MAX_LINE - 6) push_byte("x");
        push_byte("q");
        push_verb(VERB_STATE, -1, VERB_LEN[VERB_STATE]);
        push_byte(LINE_END);

        // random lines
        base  = rx_bytes_todo.size();
        lines = 0;
        while (rx_bytes_todo.size() - base < RANDOM_BYTES || lines < RANDOM_LINES) begin
            push_random_line();
            lines++;
        end

        // single reset pulse
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            begin
                while (rx_bytes_todo.size() > 0 || s_tvalid || pending_replies.size() > 0)
                    @(posedge aclk);
                repeat (DRAIN_CYCLES) @(posedge aclk);
            end
            begin
                repeat (CYCLE_LIMIT) @(posedge aclk);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && errors == 0)
            $display("uart_led_command_parser verification clean");
        else
            $display("uart_led_command_parser verification failed");
        $finish;
    end

endmodule

[files.f]
sv/ulcp_pkg.sv
sv/uart_led_command_parser.sv
tb/tb_uart_led_command_parser.sv
